@@ rtl/rqst_pkg.sv @@
// ----------------------------------------------------------------------------
// rqst_pkg
// Types and constants shared by the request sequence tracker and its checker.
// ----------------------------------------------------------------------------
package rqst_pkg;

  localparam int unsigned ENTRIES   = 256;
  localparam int unsigned SEQ_COUNT = 64;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned SEQ_W     = $clog2(SEQ_COUNT);

  localparam logic [5:0] FUNC_MASK = 6'h3E;

  localparam logic [1:0] OP_ISSUE  = 2'd0;
  localparam logic [1:0] OP_RESP   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_NOSEQ   = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [5:0]       func;
    logic [7:0]       cmd;
    logic [19:0]      remaining;
    logic [31:0]      tag;
    logic [15:0]      port;
  } entry_t;

endpackage

@@ rtl/request_sequence_tracker.sv @@
// ----------------------------------------------------------------------------
// request_sequence_tracker
// Outstanding request table with sequence assignment, response matching and
// timeout expiry.
// ----------------------------------------------------------------------------
// Every beat is handled one at a time by sweeping the 256-entry table memory,
// one entry per cycle through a registered read port. An issue that found a free
// entry then searches the sequence space for a free sequence number. An unused
// operation code skips the sweep and goes straight to the result.
// The input is taken again as soon as a result has been staged; a finished
// result waits in the output register until it is taken.
module request_sequence_tracker
  import rqst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  func_code_i,
  input  logic [7:0]  command_i,
  input  logic [5:0]  resp_seq_i,
  input  logic [19:0] timeout_ms_i,
  input  logic [31:0] request_tag_i,
  input  logic [15:0] reply_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [5:0]  seq_out_o,
  output logic [31:0] tag_out_o,
  output logic [15:0] port_out_o,
  output logic [8:0]  expired_count_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [15:0]        period_q;
  logic [ENTRIES-1:0] valid_q;
  logic [SEQ_W-1:0]   ptr_q;
  logic [IDX_W:0]     scan_cnt_q;
  logic               pend_q;
  logic [IDX_W-1:0]   pidx_q;
  logic [SEQ_COUNT-1:0] used_q;
  logic               free_found_q;
  logic [IDX_W-1:0]   free_q;
  logic               hit_q;
  logic [SEQ_W-1:0]   seq_i_q;

  logic [1:0]  op_q;
  logic [5:0]  func_q;
  logic [7:0]  cmd_q;
  logic [SEQ_W-1:0] rseq_q;
  logic [19:0] tmo_q;
  logic [31:0] tag_q;
  logic [15:0] port_q;

  logic [1:0]  res_status_q;
  logic [5:0]  res_seq_q;
  logic [31:0] res_tag_q;
  logic [15:0] res_port_q;
  logic [8:0]  res_count_q;

  entry_t mem [ENTRIES];
  entry_t rd_data_q;
  entry_t wdata;
  logic   we;
  logic [IDX_W-1:0] waddr;
  logic   re;

  logic in_fire, ent_live, key_match, expire, seq_end, seq_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign re         = (state_q == S_SCAN) && !scan_cnt_q[IDX_W];

  assign ent_live  = pend_q && valid_q[pidx_q];
  assign key_match = (rd_data_q.func == func_q) && (rd_data_q.cmd == cmd_q);
  assign expire    = rd_data_q.remaining <= {4'd0, period_q};
  assign seq_end   = (seq_i_q + 1'b1) == ptr_q;
  assign seq_free  = !used_q[seq_i_q];

  always_comb begin
    we    = 1'b0;
    waddr = pidx_q;
    wdata = rd_data_q;
    if (state_q == S_SEARCH) begin
      we    = !seq_end && seq_free;
      waddr = free_q;
      wdata = '{seq: seq_i_q, func: func_q, cmd: cmd_q, remaining: tmo_q,
                tag: tag_q, port: port_q};
    end else if (ent_live && op_q == OP_TICK && !expire) begin
      we = 1'b1;
      wdata.remaining = rd_data_q.remaining - {4'd0, period_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q <= mem[scan_cnt_q[IDX_W-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (operation_i inside {OP_ISSUE, OP_RESP, OP_TICK}) ? S_SCAN : S_RESULT;
        end
      end
      S_SCAN: begin
        if (scan_cnt_q[IDX_W] && !pend_q) begin
          state_d = (op_q == OP_ISSUE && free_found_q) ? S_SEARCH : S_RESULT;
        end
      end
      S_SEARCH: begin
        if (seq_end || seq_free) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_o || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      period_q     <= 16'd100;
      valid_q      <= '0;
      ptr_q        <= '0;
      scan_cnt_q   <= '0;
      pend_q       <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      pend_q <= re;
      if (re) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      if (in_fire) begin
        scan_cnt_q <= '0;
      end
      if (ent_live) begin
        if (op_q == OP_TICK && expire) begin
          valid_q[pidx_q] <= 1'b0;
        end
        if (op_q == OP_RESP && !hit_q && key_match && rd_data_q.seq == rseq_q) begin
          valid_q[pidx_q] <= 1'b0;
        end
      end
      if (state_q == S_SEARCH && !seq_end && seq_free) begin
        valid_q[free_q] <= 1'b1;
        ptr_q           <= seq_i_q + 1'b1;
      end
      if (state_q == S_RESULT && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Payload and working registers; control above decides when they matter.
  always_ff @(posedge clk_i) begin
    pidx_q <= scan_cnt_q[IDX_W-1:0];
    if (in_fire) begin
      op_q         <= operation_i;
      func_q       <= func_code_i & FUNC_MASK;
      cmd_q        <= command_i;
      rseq_q       <= resp_seq_i[SEQ_W-1:0];
      tmo_q        <= timeout_ms_i;
      tag_q        <= request_tag_i;
      port_q       <= reply_port_i;
      used_q       <= '0;
      free_found_q <= 1'b0;
      hit_q        <= 1'b0;
      res_status_q <= (operation_i == OP_RESP) ? ST_NOMATCH : ST_OK;
      res_seq_q    <= '0;
      res_tag_q    <= '0;
      res_port_q   <= '0;
      res_count_q  <= '0;
    end
    if (pend_q) begin
      case (op_q)
        OP_ISSUE: begin
          if (ent_live && key_match) begin
            used_q[rd_data_q.seq] <= 1'b1;
          end
          if (!valid_q[pidx_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_q       <= pidx_q;
          end
        end
        OP_RESP: begin
          if (ent_live && !hit_q && key_match && rd_data_q.seq == rseq_q) begin
            hit_q        <= 1'b1;
            res_status_q <= ST_OK;
            res_seq_q    <= 6'(rseq_q);
            res_tag_q    <= rd_data_q.tag;
            res_port_q   <= rd_data_q.port;
          end
        end
        OP_TICK: begin
          if (ent_live && expire && res_count_q != 9'h1FF) begin
            res_count_q <= res_count_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (state_q == S_SCAN && scan_cnt_q[IDX_W] && !pend_q && op_q == OP_ISSUE) begin
      seq_i_q <= ptr_q;
      if (!free_found_q) begin
        res_status_q <= ST_NOFREE;
      end
    end
    if (state_q == S_SEARCH) begin
      if (seq_end) begin
        res_status_q <= ST_NOSEQ;
      end else if (seq_free) begin
        res_seq_q <= 6'(seq_i_q);
      end else begin
        seq_i_q <= seq_i_q + 1'b1;
      end
    end
    if (state_q == S_RESULT && (!out_valid_o || out_ready_i)) begin
      status_o        <= res_status_q;
      seq_out_o       <= res_seq_q;
      tag_out_o       <= res_tag_q;
      port_out_o      <= res_port_q;
      expired_count_o <= res_count_q;
    end
  end

endmodule

@@ rtl/rqst_checker.sv @@
// ----------------------------------------------------------------------------
// rqst_checker
// Port-level checks for the request sequence tracker.
// ----------------------------------------------------------------------------
module rqst_checker
  import rqst_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [5:0]  seq_out_o,
  input logic [31:0] tag_out_o,
  input logic [15:0] port_out_o,
  input logic [8:0]  expired_count_o
);

  // A pending result beat holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result beat changed while stalled");

  // Only one beat is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NOMATCH |->
      seq_out_o == '0 && tag_out_o == '0 && port_out_o == '0 && expired_count_o == '0)
    else $error("unmatched response carries data");

  a_fail_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NOFREE || status_o == ST_NOSEQ) |->
      seq_out_o == '0 && tag_out_o == '0 && expired_count_o == '0)
    else $error("failed issue carries data");

endmodule

bind request_sequence_tracker rqst_checker u_rqst_checker (.*);
